[design/ucv_pkg.sv]
// ucv_pkg: shared constants, status codes and the lead-byte decoder for the
// UTF-8 character validator. No dependencies.
`timescale 1ns / 1ps

package ucv_pkg;

  // Longest character the block accepts, in bytes.
  localparam int unsigned MAX_SEQ_LEN = 6;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CP_W       = 16;
  localparam int unsigned RES_W      = STATUS_W + LEN_W + CP_W;
  localparam int unsigned RES_BYTES_W = ((RES_W + 7) / 8) * 8;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_VALID    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CONT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SURR     = 3'd4;

  // Character length announced by a lead byte, 0 if the byte cannot lead.
  function automatic logic [LEN_W-1:0] lead_length(input logic [DATA_W-1:0] b);
    logic [LEN_W-1:0] len;
    priority casez (b)
      8'b0???????: len = 3'd1;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      8'b111110??: len = 3'd5;
      8'b1111110?: len = 3'd6;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

[design/utf8_char_validator.sv]
// utf8_char_validator: top level, byte-stream UTF-8 checker and decoder.
// Depends on ucv_pkg.
`timescale 1ns / 1ps
//
// Usage:
//  - Slave stream (s_axis_*): one byte of the string per transaction, tlast
//    set on the final byte of the string.
//  - Master stream (m_axis_*): one transaction per finished or failed
//    character: status, byte count and code point in tdata, tlast copies the
//    end-of-string flag of the byte that closed the result. Continuation
//    bytes in the middle of a character give no transaction.
//  - Path: the accepted byte sits in the input register until the result
//    slot is free; the result register then loads from it and drives tvalid,
//    and the result transaction completes once m_axis_tready is high.
//  - Throughput: one byte per clock while m_axis_tready does not stall the
//    result, set by the single decode step between the input and result registers.
//  - Stall: when m_axis_tready is low the result holds; the input register
//    still takes one byte, and further bytes are refused only once both the
//    result and the input register are full.
//  - Reset: clears both valid flags and the character state (no character
//    open, count and partial value zero).
//  - Status codes: valid, bad lead, bad continuation, truncated, surrogate;
//    after any result the next byte is taken as a fresh lead.

module utf8_char_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [2:0] status, [5:3] char_length,
                                        // [21:6] code_point, [23:22] zero
  output logic        m_axis_tlast_o    // string_done
);

  localparam int unsigned LenW = ucv_pkg::LEN_W;
  localparam int unsigned CpW  = ucv_pkg::CP_W;

  // Input register
  logic                        in_vld_q;
  logic [ucv_pkg::DATA_W-1:0]  in_byte_q;
  logic                        in_last_q;

  // Character state
  logic [LenW-1:0] exp_len_q, exp_len_d;
  logic [LenW-1:0] rcv_cnt_q, rcv_cnt_d;
  logic [CpW-1:0]  partial_q, partial_d;

  // Result register
  logic                          out_vld_q;
  logic [ucv_pkg::STATUS_W-1:0]  out_status_q, res_status;
  logic [LenW-1:0]               out_len_q, res_len;
  logic [CpW-1:0]                out_cp_q, res_cp;
  logic                          out_last_q;

  logic            advance;
  logic            emit;
  logic [LenW-1:0] lead_len;
  logic [LenW-1:0] cnt_inc;
  logic [CpW-1:0]  pv_next;

  // Byte in the input register moves on when the result slot is free.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  assign lead_len = ucv_pkg::lead_length(in_byte_q);
  assign cnt_inc  = rcv_cnt_q + 3'd1;
  // Only 1..3 byte characters accumulate a code point.
  assign pv_next  = (exp_len_q <= 3'd3) ? {partial_q[CpW-7:0], in_byte_q[5:0]} : partial_q;

  always_comb begin
    exp_len_d  = exp_len_q;
    rcv_cnt_d  = rcv_cnt_q;
    partial_d  = partial_q;
    emit       = 1'b0;
    res_status = ucv_pkg::ST_VALID;
    res_len    = '0;
    res_cp     = '0;
    if (advance) begin
      if (exp_len_q == '0) begin
        // expecting a lead byte
        if (lead_len == '0 || lead_len > LenW'(ucv_pkg::MAX_SEQ_LEN)) begin
          emit       = 1'b1;
          res_status = ucv_pkg::ST_BAD_LEAD;
        end else if (lead_len == 3'd1) begin
          emit    = 1'b1;
          res_len = 3'd1;
          res_cp  = {{(CpW-8){1'b0}}, in_byte_q};
        end else if (in_last_q) begin
          emit       = 1'b1;
          res_status = ucv_pkg::ST_TRUNC;
          res_len    = 3'd2;
        end else begin
          exp_len_d = lead_len;
          rcv_cnt_d = 3'd1;
          if (lead_len == 3'd2) begin
            partial_d = {{(CpW-5){1'b0}}, in_byte_q[4:0]};
          end else if (lead_len == 3'd3) begin
            partial_d = {{(CpW-4){1'b0}}, in_byte_q[3:0]};
          end else begin
            partial_d = '0;
          end
        end
      end else if (in_byte_q[7:6] != 2'b10) begin
        emit       = 1'b1;
        res_status = ucv_pkg::ST_BAD_CONT;
        res_len    = cnt_inc;
      end else if (cnt_inc >= exp_len_q) begin
        emit    = 1'b1;
        res_len = exp_len_q;
        if (exp_len_q == 3'd3 && pv_next[15:11] == 5'b11011) begin
          res_status = ucv_pkg::ST_SURR;
        end else if (exp_len_q <= 3'd3) begin
          res_cp = pv_next;
        end
      end else if (in_last_q) begin
        emit       = 1'b1;
        res_status = ucv_pkg::ST_TRUNC;
        res_len    = cnt_inc + 3'd1;
      end else begin
        rcv_cnt_d = cnt_inc;
        partial_d = pv_next;
      end
      if (emit) begin
        exp_len_d = '0;
        rcv_cnt_d = '0;
        partial_d = '0;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      exp_len_q <= '0;
      rcv_cnt_q <= '0;
      partial_q <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      exp_len_q <= exp_len_d;
      rcv_cnt_q <= rcv_cnt_d;
      partial_q <= partial_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && emit) begin
      out_status_q <= res_status;
      out_len_q    <= res_len;
      out_cp_q     <= res_cp;
      out_last_q   <= in_last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(ucv_pkg::RES_BYTES_W - ucv_pkg::RES_W){1'b0}},
                            out_cp_q, out_len_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

[design/ucv_checker.sv]
// ucv_checker: port-level assertions for utf8_char_validator, bound to it.
// Depends on ucv_pkg and the top level's port list.
`timescale 1ns / 1ps

module ucv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic [2:0]  st;
  logic [2:0]  len;
  logic [15:0] cp;

  assign st  = m_axis_tdata_o[2:0];
  assign len = m_axis_tdata_o[5:3];
  assign cp  = m_axis_tdata_o[21:6];

  // Stalled result holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed under stall");

  // Only defined status codes leave the block.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> st <= ucv_pkg::ST_SURR)
    else $error("undefined status");

  // A bad lead counts no bytes; any other result counts at least one.
  a_bad_lead_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((st == ucv_pkg::ST_BAD_LEAD) == (len == 3'd0)))
    else $error("length inconsistent with status");

  // Failures and long characters carry no code point.
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (st != ucv_pkg::ST_VALID || len >= 3'd4) |-> cp == 16'd0)
    else $error("code point on failure or long character");

  // A valid one-byte character is ASCII.
  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ucv_pkg::ST_VALID && len == 3'd1 |-> cp[15:7] == 9'd0)
    else $error("one-byte character above 0x7F");

endmodule

bind utf8_char_validator ucv_checker u_ucv_checker (.*);

[dv/testbench.sv]
// testbench: self-checking stream test of utf8_char_validator. Bytes go in on the
// slave stream, decoded character results are checked against an in-bench decoder.
// Depends on ucv_pkg and the utf8_char_validator RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASE_BYTES = 110;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_PRINTS  = 40;

  localparam int unsigned DataW     = ucv_pkg::DATA_W;
  localparam int unsigned StatusW   = ucv_pkg::STATUS_W;
  localparam int unsigned LenW      = ucv_pkg::LEN_W;
  localparam int unsigned CpW       = ucv_pkg::CP_W;
  localparam int unsigned ResW      = ucv_pkg::RES_W;
  localparam int unsigned ResBytesW = ucv_pkg::RES_BYTES_W;

  // One byte of the string, its end-of-string flag, and a flag that holds it back
  // until the result queue has drained.
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             eos;
    logic             drain;
  } byte_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    len;
    logic [CpW-1:0]     cp;
    logic               done;
  } char_res_t;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata  = '0;
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [ResBytesW-1:0] m_tdata;
  logic                 m_tlast;

  utf8_char_validator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  byte_item_t  byte_q[$];
  char_res_t   char_q[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_ack      = 0;
  int unsigned hold_left     = 0;
  int unsigned cycles        = 0;
  int unsigned mismatches    = 0;
  int unsigned bytes_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned blocked_cycles = 0;
  int unsigned status_hits[5];
  int unsigned queued        = 0;
  bit          in_taken      = 1'b0;

  // Decoder state: length of the open character (0 = none), bytes seen so far
  // and the value built up from them.
  logic [LenW-1:0] open_len = '0;
  logic [LenW-1:0] seen_cnt = '0;
  logic [CpW-1:0]  acc_val  = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned leading_ones(input logic [7:0] b);
    int unsigned n = 0;
    while (n < 8 && b[7-n]) n++;
    return n;
  endfunction

  // Works out the result (if any) that one accepted byte causes.
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    int unsigned n;
    char_res_t   r;
    bit          fire;
    r = '0;
    r.done = eos;
    fire = 1'b0;
    if (open_len == 0) begin
      n = leading_ones(b);
      if (n == 0) n = 1;
      else if (n == 1 || n > ucv_pkg::MAX_SEQ_LEN) n = 0;
      if (n == 0) begin
        r.status = ucv_pkg::ST_BAD_LEAD;
        fire = 1'b1;
      end else if (n == 1) begin
        r.status = ucv_pkg::ST_VALID;
        r.len = 3'd1;
        r.cp = {8'h00, b};
        fire = 1'b1;
      end else if (eos) begin
        // lead of a multi-byte character on the last byte of the string
        r.status = ucv_pkg::ST_TRUNC;
        r.len = 3'd2;
        fire = 1'b1;
      end else begin
        open_len = LenW'(n);
        seen_cnt = 3'd1;
        acc_val = (n == 2) ? CpW'(b[4:0]) : (n == 3) ? CpW'(b[3:0]) : '0;
      end
    end else if (b[7:6] != 2'b10) begin
      // non-continuation byte is swallowed, even with end of string
      r.status = ucv_pkg::ST_BAD_CONT;
      r.len = seen_cnt + 3'd1;
      fire = 1'b1;
    end else begin
      seen_cnt = seen_cnt + 3'd1;
      if (open_len <= 3) acc_val = {acc_val[CpW-7:0], b[5:0]};
      if (seen_cnt >= open_len) begin
        fire = 1'b1;
        r.len = open_len;
        if (open_len == 3 && acc_val >= 16'hD800 && acc_val <= 16'hDFFF) begin
          r.status = ucv_pkg::ST_SURR;
        end else begin
          r.status = ucv_pkg::ST_VALID;
          r.cp = (open_len <= 3) ? acc_val : '0;
        end
      end else if (eos) begin
        r.status = ucv_pkg::ST_TRUNC;
        r.len = seen_cnt + 3'd1;
        fire = 1'b1;
      end
    end
    if (fire) begin
      char_q = {char_q, r};
      status_hits[r.status]++;
      open_len = '0;
      seen_cnt = '0;
      acc_val = '0;
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eos, input logic drain);
    byte_item_t it;
    it.data = b;
    it.eos = eos;
    it.drain = drain;
    byte_q = {byte_q, it};
    queued++;
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned len);
    logic [7:0] b;
    case (len)
      1: b = {1'b0, 7'($urandom)};
      2: b = {3'b110, 5'($urandom)};
      3: b = ($urandom_range(0, 3) == 0) ? 8'hED : {4'b1110, 4'($urandom)};
      4: b = {5'b11110, 3'($urandom)};
      5: b = {6'b111110, 2'($urandom)};
      default: b = {7'b1111110, 1'($urandom)};
    endcase
    return b;
  endfunction

  // Mostly well-formed characters; the rest are cut short by end of string,
  // broken by a non-continuation byte, or plain noise.
  task automatic add_random_char();
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    logic [7:0]  b;
    logic        eos;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    if (pick >= 95) begin
      add_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 49) == 0);
      return;
    end
    if (pick >= 80 && len == 1) len = $urandom_range(2, 6);
    keep = (pick < 80) ? len : $urandom_range(1, len - 1);
    for (int unsigned k = 0; k < keep; k++) begin
      b = (k == 0) ? lead_byte(len) : {2'b10, 6'($urandom)};
      if (pick < 80) eos = (k == keep - 1) && ($urandom_range(0, 7) == 0);
      else eos = (pick < 88) && (k == keep - 1);
      add_byte(b, eos, $urandom_range(0, 49) == 0);
    end
    if (pick >= 88) begin
      b = 8'($urandom);
      while (b[7:6] == 2'b10) b = 8'($urandom);
      add_byte(b, $urandom_range(0, 3) == 0, 1'b0);
    end
  endtask

  task automatic drain_all();
    while (byte_q.size() != 0 || s_tvalid || char_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                  input bit long_hold);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    queued = 0;
    // first byte of every phase waits for all results of the previous one
    add_byte(8'h41, 1'b0, 1'b1);
    if (long_hold) hold_req++;
    while (queued < PHASE_BYTES) add_random_char();
    drain_all();
  endtask

  // Sender: presents the next queued byte at the falling edge once the
  // previous one has been taken, with random gaps.
  always @(negedge clk_i) begin : driver
    byte_item_t nxt;
    if (rst_ni && (!s_tvalid || in_taken)) begin
      if (byte_q.size() != 0 && !(byte_q[0].drain && char_q.size() != 0) &&
          $urandom_range(1, 100) > src_idle_pct) begin
        nxt = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.data;
        s_tlast <= nxt.eos;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin : sink
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(1, 100) > snk_stall_pct);
    end
  end

  // Checks results first, then predicts from the byte taken at this edge.
  always @(posedge clk_i) begin : scoreboard
    char_res_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected, tdata %h", m_tdata));
        end else begin
          want = char_q.pop_front();
          if (m_tdata[StatusW-1:0] !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d", results_seen,
                                      m_tdata[StatusW-1:0], want.status));
          if (m_tdata[StatusW+LenW-1:StatusW] !== want.len)
            report_mismatch($sformatf("result %0d length %0d, want %0d", results_seen,
                                      m_tdata[StatusW+LenW-1:StatusW], want.len));
          if (m_tdata[ResW-1:StatusW+LenW] !== want.cp)
            report_mismatch($sformatf("result %0d code point %h, want %h", results_seen,
                                      m_tdata[ResW-1:StatusW+LenW], want.cp));
          if (m_tdata[ResBytesW-1:ResW] !== '0)
            report_mismatch($sformatf("result %0d pad bits %b", results_seen,
                                      m_tdata[ResBytesW-1:ResW]));
          if (m_tlast !== want.done)
            report_mismatch($sformatf("result %0d string_done %b, want %b", results_seen,
                                      m_tlast, want.done));
        end
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (s_tvalid && !s_tready) blocked_cycles++;
      in_taken = s_tvalid && s_tready;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, char_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes and every status
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b1, 1'b0);
    add_byte(8'hC3, 1'b0, 1'b0);     // two-byte character
    add_byte(8'hA9, 1'b0, 1'b0);
    add_byte(8'hED, 1'b0, 1'b0);     // surrogate D800
    add_byte(8'hA0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hFC, 1'b0, 1'b0);     // six-byte character, code point dropped
    for (int i = 0; i < 5; i++) add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);     // continuation as lead
    add_byte(8'hFE, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'hC3, 1'b0, 1'b0);     // zero byte breaks the character
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hE2, 1'b0, 1'b0);     // bad continuation carrying end of string
    add_byte(8'h41, 1'b1, 1'b0);
    add_byte(8'hE2, 1'b1, 1'b0);     // truncated on the lead
    add_byte(8'hE2, 1'b0, 1'b0);     // truncated after one continuation
    add_byte(8'h82, 1'b1, 1'b0);
    add_byte(8'hEF, 1'b0, 1'b0);     // largest three-byte value
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b1, 1'b0);
    drain_all();

    run_random_phase(0, 0, 1'b0);
    run_random_phase(0, 0, 1'b1);    // long receiver hold-off, input backs up
    run_random_phase(62, 0, 1'b0);
    run_random_phase(0, 62, 1'b0);
    run_random_phase(38, 38, 1'b0);

    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d results in %0d cycles (%0d with input blocked).",
             bytes_taken, results_seen, cycles, blocked_cycles);
    $display("Statuses: valid %0d, bad lead %0d, bad cont %0d, truncated %0d, surrogate %0d.",
             status_hits[ucv_pkg::ST_VALID], status_hits[ucv_pkg::ST_BAD_LEAD],
             status_hits[ucv_pkg::ST_BAD_CONT], status_hits[ucv_pkg::ST_TRUNC],
             status_hits[ucv_pkg::ST_SURR]);
    if (mismatches == 0 && char_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
